[rtl/core/pool_first_fit_allocator_unit_assert.svh]
// Assertion macros used by the allocator checker.
`ifndef POOL_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define POOL_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PFFA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/pffa_pkg.sv]
// Shared types and constants of the first-fit pool allocator.
`timescale 1ns / 1ps
package pffa_pkg;

   localparam int SIZE_W          = 21;
   localparam int OFFSET_BITS     = 20;
   localparam int REQ_DATA_W      = 48;
   localparam int RSP_DATA_W      = 24;
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [SIZE_W-1:0] POOL_SIZE_RESET = 21'h100000;
   localparam logic [SIZE_W-1:0] OFFSET_SPAN     = 21'h100000;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } pffa_op_type;

   typedef struct packed {
      pffa_op_type            op;
      logic [SIZE_W-1:0]      size;
      logic [OFFSET_BITS-1:0] offset;
   } pffa_cmd_type;

   typedef struct packed {
      logic                   free;
      logic [SIZE_W-1:0]      size;
      logic [SIZE_W-1:0]      used;
      logic [OFFSET_BITS-1:0] offset;
   } pffa_entry_type;

endpackage

[rtl/core/pffa_front.sv]
// Input stage: takes request transactions and decodes them into commands.
`timescale 1ns / 1ps
module pffa_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [20:0] request_size, [40:21] release_offset, [47:41] zero
   input  logic [pffa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] cmd
   input  logic                             req_tuser,
   output logic                             push_valid,
   input  logic                             push_ready,
   output pffa_pkg::pffa_cmd_type           push_cmd
);
   import pffa_pkg::*;

   logic         valid_ff, valid_in;
   pffa_cmd_type cmd_ff, cmd_in;
   logic         accept;

   assign req_tready = !valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      valid_in = valid_ff && !push_ready;
      cmd_in   = cmd_ff;
      if (accept) begin
         valid_in      = 1'b1;
         cmd_in.op     = req_tuser ? OP_FREE : OP_ALLOC;
         cmd_in.size   = req_tdata[SIZE_W-1:0];
         cmd_in.offset = req_tdata[SIZE_W +: OFFSET_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

[rtl/core/pffa_queue.sv]
// Short command queue between the front stage and the table engine.
`timescale 1ns / 1ps
module pffa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  pffa_pkg::pffa_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output pffa_pkg::pffa_cmd_type pop_cmd
);
   import pffa_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pffa_cmd_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/pffa_engine.sv]
// Table engine: walks the allocation table and produces one result per command.
`timescale 1ns / 1ps
module pffa_engine #(
   parameter int MAX_ENTRIES = pffa_pkg::DEF_MAX_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pffa_pkg::SIZE_W-1:0]       pool_size,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  pffa_pkg::pffa_cmd_type            pop_cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pffa_pkg::OFFSET_BITS-1:0]  rsp_offset,
   output logic                              rsp_ok
);
   import pffa_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_CARVE,
      ST_FIN
   } state_type;

   pffa_entry_type entry_mem [MAX_ENTRIES];
   pffa_entry_type rd_data_ff;

   state_type              state_ff, state_in;
   pffa_cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SIZE_W-1:0]      top_ff, top_in;
   logic [CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   pffa_entry_type         carve_ff, carve_in;
   logic [OFFSET_BITS-1:0] res_off_ff, res_off_in;
   logic                   res_ok_ff, res_ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_BITS-1:0] rsp_off_ff, rsp_off_in;
   logic                   rsp_ok_ff, rsp_ok_in;

   logic                   issue;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   pffa_entry_type         wr_data;
   logic                   full;
   logic [SIZE_W-1:0]      tail;
   logic                   fit_reuse, fit_carve;
   logic [OFFSET_BITS-1:0] carve_off;
   logic [SIZE_W-1:0]      limit;
   logic [SIZE_W:0]        bump_sum;
   logic                   bump_fit;

   assign issue   = (state_ff == ST_WALK) && (rd_cnt_ff < count_ff);
   assign rd_addr = rd_cnt_ff[IDX_W-1:0];
   assign full    = count_ff == CNT_W'(MAX_ENTRIES);

   // Evaluate the entry read in the previous cycle
   assign tail      = rd_data_ff.size - rd_data_ff.used;
   assign fit_reuse = rd_data_ff.free && (rd_data_ff.size >= cmd_ff.size);
   assign fit_carve = (rd_data_ff.size >= rd_data_ff.used) && (tail >= cmd_ff.size);
   assign carve_off = rd_data_ff.offset + rd_data_ff.used[OFFSET_BITS-1:0];

   // Bump end is the smaller of the pool size and the offset span
   assign limit    = (pool_size > OFFSET_SPAN) ? OFFSET_SPAN : pool_size;
   assign bump_sum = {1'b0, top_ff} + {1'b0, cmd_ff.size};
   assign bump_fit = (top_ff < limit) && (bump_sum <= {1'b0, limit});

   assign pop_ready  = state_ff == ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_offset = rsp_off_ff;
   assign rsp_ok     = rsp_ok_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      rd_cnt_in    = rd_cnt_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      carve_in     = carve_ff;
      res_off_in   = res_off_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_off_in   = rsp_off_ff;
      rsp_ok_in    = rsp_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_idx_ff;
      wr_data      = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in    = pop_cmd;
               rd_cnt_in = '0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (issue) begin
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_addr;
            end
            if (pend_ff) begin
               if (cmd_ff.op == OP_FREE) begin
                  if (rd_data_ff.offset == cmd_ff.offset) begin
                     wr_en        = 1'b1;
                     wr_data.free = 1'b1;
                     wr_data.used = '0;
                  end
               end else if (fit_reuse) begin
                  wr_en        = 1'b1;
                  wr_data.free = 1'b0;
                  wr_data.used = cmd_ff.size;
                  res_ok_in    = 1'b1;
                  res_off_in   = rd_data_ff.offset;
                  pend_in      = 1'b0;
                  state_in     = ST_FIN;
               end else if (fit_carve) begin
                  pend_in = 1'b0;
                  if (full) begin
                     // no room for the tail entry: fail, table untouched
                     res_ok_in  = 1'b0;
                     res_off_in = '0;
                     state_in   = ST_FIN;
                  end else begin
                     wr_en           = 1'b1;
                     wr_data.size    = rd_data_ff.used;
                     carve_in.free   = 1'b0;
                     carve_in.size   = tail;
                     carve_in.used   = cmd_ff.size;
                     carve_in.offset = carve_off;
                     res_ok_in       = 1'b1;
                     res_off_in      = carve_off;
                     state_in        = ST_CARVE;
                  end
               end
            end else if (!issue) begin
               // walk done: a free, or an allocate without a hit
               state_in = ST_FIN;
               if (cmd_ff.op == OP_FREE) begin
                  res_ok_in  = 1'b1;
                  res_off_in = '0;
               end else if (bump_fit && !full) begin
                  wr_en          = 1'b1;
                  wr_addr        = count_ff[IDX_W-1:0];
                  wr_data.free   = 1'b0;
                  wr_data.size   = cmd_ff.size;
                  wr_data.used   = cmd_ff.size;
                  wr_data.offset = top_ff[OFFSET_BITS-1:0];
                  count_in       = count_ff + CNT_W'(1);
                  top_in         = bump_sum[SIZE_W-1:0];
                  res_ok_in      = 1'b1;
                  res_off_in     = top_ff[OFFSET_BITS-1:0];
               end else begin
                  res_ok_in  = 1'b0;
                  res_off_in = '0;
               end
            end
         end
         ST_CARVE: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[IDX_W-1:0];
            wr_data  = carve_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = res_off_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rd_cnt_ff   <= rd_cnt_in;
      pend_idx_ff <= pend_idx_in;
      carve_ff    <= carve_in;
      res_off_ff  <= res_off_in;
      res_ok_ff   <= res_ok_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

endmodule

[rtl/core/pool_first_fit_allocator_unit.sv]
// Top level of the first-fit pool allocator.
`timescale 1ns / 1ps
// First-fit pool allocator. Each request transaction (allocate or free) yields exactly
// one response transaction, in order. An allocate takes the first entry that is free
// and large enough (reuse) or has an unused tail large enough (carve, which fails if
// the table is full), else bumps the top of pool; a free marks every entry at the
// given offset free. Requests go through a two-deep command queue, so the request side
// keeps taking transactions while the table engine is busy, until the queue fills.
// The engine handles one command at a time; its walk time is set by the single read
// port of the entry memory, walked one entry per cycle. No clearing pass follows
// reset: only entries below the fill count are read. pool_size is written through
// csr_wr_en/csr_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce.
module pool_first_fit_allocator_unit #(
   parameter int MAX_ENTRIES = pffa_pkg::DEF_MAX_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [20:0] request_size, [40:21] release_offset, [47:41] zero
   input  logic [pffa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] cmd
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [19:0] granted_offset, [23:20] zero
   output logic [pffa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] ok
   output logic                             rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [pffa_pkg::SIZE_W-1:0]      csr_wr_data
);
   import pffa_pkg::*;

   logic [SIZE_W-1:0]      pool_size_ff;
   logic                   push_valid, push_ready;
   pffa_cmd_type           push_cmd;
   logic                   pop_valid, pop_ready;
   pffa_cmd_type           pop_cmd;
   logic [OFFSET_BITS-1:0] rsp_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= POOL_SIZE_RESET;
      end else if (csr_wr_en) begin
         pool_size_ff <= csr_wr_data;
      end
   end

   pffa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   pffa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   pffa_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .pool_size  (pool_size_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_offset (rsp_offset),
      .rsp_ok     (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W - OFFSET_BITS){1'b0}}, rsp_offset};

endmodule

[rtl/core/pffa_checker.sv]
// Port-level checks of the allocator, bound to the top level.
`timescale 1ns / 1ps
`include "pool_first_fit_allocator_unit_assert.svh"
module pffa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pffa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser
);
   import pffa_pkg::*;

   `PFFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")
   `PFFA_ASSERT_IMPLY(a_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid, "response valid right after reset")
   `PFFA_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "failed allocation carries a nonzero offset")
   `PFFA_ASSERT_IMPLY(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:OFFSET_BITS] == '0, "response padding not zero")

endmodule

bind pool_first_fit_allocator_unit pffa_checker u_pffa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
